>>> hdl/pplb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pplb_pkg
// Shared types, sizes and helpers of the ping-pong line buffer.
// ----------------------------------------------------------------------------
package pplb_pkg;

	// bytes per line buffer, terminator slot included
	localparam int LINE_CAPACITY = 64;

	// derived sizes
	localparam int LEN_W     = $clog2(LINE_CAPACITY);
	localparam int ADDR_W    = $clog2(2 * LINE_CAPACITY);
	localparam int STORE_DEPTH = 2 * LINE_CAPACITY;

	// fixed field widths
	localparam int BYTE_W    = 8;
	localparam int OUT_LEN_W = 6;
	localparam int REQ_W     = 2;

	// line terminators
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

	// event kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_RX       = 2'd0,
		REQ_TX_EMPTY = 2'd1,
		REQ_TX_DONE  = 2'd2,
		REQ_ARM      = 2'd3
	} req_t;

	// result word without the byte read from the store
	typedef struct packed {
		logic                 tx_valid;
		logic                 line_done;
		logic [OUT_LEN_W-1:0] line_length;
		logic                 line_buffer;
		logic                 byte_dropped;
		logic                 tx_armed_now;
	} result_t;

	// store address of a position inside one of the two buffers
	function automatic logic [ADDR_W-1:0] store_addr(input logic buf_sel,
			input logic [LEN_W-1:0] pos);
		logic [ADDR_W-1:0] base;
		base = buf_sel ? ADDR_W'(LINE_CAPACITY) : '0;
		return base + ADDR_W'(pos);
	endfunction

endpackage
`default_nettype wire

>>> hdl/pplb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pplb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pplb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/ping_pong_line_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ping_pong_line_buffer_core
// Line receiver with two ping-pong buffers and an event-driven transmitter.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one serial event per word: tuser carries the
//   event kind (received byte, transmitter empty, transmit complete, arm
//   transmit) and tdata the received byte. Every event yields exactly one
//   result word on the master channel: a byte to transmit with its valid
//   flag, a line-closed report, a dropped-byte flag and the transmit enable.
//   Line bytes live in one RAM of two line buffers; lengths, positions and
//   flags live in registers and are updated in the accept cycle.
//   From accept a result passes the read stage (registered RAM read) and
//   then the output register. One word per cycle is sustained while the
//   master side takes results; the RAM has a write port for received bytes
//   and a read port for transmit bytes, which always address opposite buffers.
//   If the master side stalls, the result waits in the output register and
//   one more event can be held in the read stage; s_tready falls only when
//   both are full. Reset empties both stages, selects buffer 0 for receive,
//   clears lengths, transmit position and flags; the RAM is not cleared.
// ----------------------------------------------------------------------------
module ping_pong_line_buffer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave channel
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] req_type
	// master channel
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// [7:0] tx_byte, [13:8] line_length, [14] line_buffer, [15] byte_dropped,
	// [16] tx_armed_now, [23:17] zero
	output      logic [23:0] m_tdata,
	output      logic [1:0]  m_tuser    // [0] tx_valid, [1] line_done
);
	import pplb_pkg::*;

	// control state
	logic             active_q;
	logic [LEN_W-1:0] len0_q, len1_q;
	logic [LEN_W-1:0] tx_pos_q;
	logic             armed_q;
	logic             comp_q;

	logic             active_d;
	logic [LEN_W-1:0] len0_d, len1_d;
	logic [LEN_W-1:0] tx_pos_d;
	logic             armed_d;
	logic             comp_d;

	// pipeline
	logic             valid_s1;
	result_t          res_s1;
	result_t          res_d;
	logic             out_free;
	logic             accept;

	// store access
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// decoded event
	req_t             req;
	logic [BYTE_W-1:0] rx_byte;
	logic             rxb, txb;
	logic [LEN_W-1:0] len_rx, len_tx;
	logic             is_term;

	assign req      = req_t'(s_tuser);
	assign rx_byte  = s_tdata;
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	assign rxb     = active_q;
	assign txb     = !active_q;
	assign len_rx  = rxb ? len1_q : len0_q;
	assign len_tx  = txb ? len1_q : len0_q;
	assign is_term = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);

	assign ram_waddr = store_addr(rxb, len_rx);
	assign ram_raddr = store_addr(txb, tx_pos_q);

	// event decode and next control state
	always_comb begin
		active_d = active_q;
		len0_d   = len0_q;
		len1_d   = len1_q;
		tx_pos_d = tx_pos_q;
		armed_d  = armed_q;
		comp_d   = comp_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		res_d    = '0;
		unique case (req)
			REQ_RX: begin
				if (is_term) begin
					res_d.line_done   = 1'b1;
					res_d.line_length = OUT_LEN_W'(len_rx);
					res_d.line_buffer = rxb;
					active_d          = !rxb;
					if (rxb) begin
						len0_d = '0;
					end else begin
						len1_d = '0;
					end
					tx_pos_d = '0;
					if (comp_q) begin
						armed_d = 1'b1;
					end
				end else if (len_rx < LEN_W'(LINE_CAPACITY - 1)) begin
					ram_we = 1'b1;
					if (rxb) begin
						len1_d = len_rx + 1'b1;
					end else begin
						len0_d = len_rx + 1'b1;
					end
				end else begin
					res_d.byte_dropped = 1'b1;
				end
			end
			REQ_TX_EMPTY: begin
				if (armed_q) begin
					if (tx_pos_q < len_tx) begin
						res_d.tx_valid = 1'b1;
						ram_re         = 1'b1;
						tx_pos_d       = tx_pos_q + 1'b1;
					end else begin
						armed_d  = 1'b0;
						comp_d   = 1'b1;
						tx_pos_d = '0;
						if (txb) begin
							len1_d = '0;
						end else begin
							len0_d = '0;
						end
					end
				end
			end
			REQ_TX_DONE: begin
				comp_d = 1'b0;
			end
			REQ_ARM: begin
				armed_d = 1'b1;
			end
			default: begin
				armed_d = armed_q;
			end
		endcase
		res_d.tx_armed_now = armed_d;
	end

	// control registers, updated on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			len0_q   <= '0;
			len1_q   <= '0;
			tx_pos_q <= '0;
			armed_q  <= 1'b0;
			comp_q   <= 1'b0;
		end else if (accept) begin
			active_q <= active_d;
			len0_q   <= len0_d;
			len1_q   <= len1_d;
			tx_pos_q <= tx_pos_d;
			armed_q  <= armed_d;
			comp_q   <= comp_d;
		end
	end

	// line store, write to receiving buffer, read from transmitting buffer
	pplb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept && ram_we),
		.waddr(ram_waddr),
		.wdata(rx_byte),
		.re   (accept && ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			m_tuser <= {res_s1.line_done, res_s1.tx_valid};
			m_tdata <= {7'd0, res_s1.tx_armed_now, res_s1.byte_dropped,
				res_s1.line_buffer, res_s1.line_length,
				res_s1.tx_valid ? ram_rdata : 8'h00};
		end
	end

endmodule
`default_nettype wire

>>> hdl/pplb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pplb_checker
// Port-level checks of the ping-pong line buffer, bound to the top level.
// ----------------------------------------------------------------------------
module pplb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one event cannot both transmit and close a line
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("tx byte and line close in one word");

	// a sent byte implies transmit still enabled
	a_armed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[16])
		else $error("byte sent while disarmed");

	// dropped byte carries no other report
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |-> !m_tuser[0] && !m_tuser[1])
		else $error("dropped byte with other report");

	// an idle channel with no pending result stays ready
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !s_tvalid |=> s_tready)
		else $error("input not ready while pipeline drains");

endmodule

bind ping_pong_line_buffer_core pplb_checker u_pplb_checker (.*);
`default_nettype wire

>>> tb/sv/tb_ping_pong_line_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ping_pong_line_buffer_core
// Self-checking bench for the ping-pong line buffer core. A short table of
// serial events (some with typed-in results) is followed by random lines,
// transmit drains and noise. Every accepted event is run through a local
// line/transmit predictor and every result word is checked field by field.
// ----------------------------------------------------------------------------
module tb_ping_pong_line_buffer_core;
	import pplb_pkg::*;

	// result word as seen on the master side, {m_tdata, m_tuser}
	typedef struct packed {
		logic [6:0] pad;
		logic       armed_now;
		logic       dropped;
		logic       closed_buf;
		logic [5:0] closed_len;
		logic [7:0] tx_char;
		logic       line_done;
		logic       tx_valid;
	} line_result_t;

	// one row of the directed table
	typedef struct packed {
		req_t         kind;
		logic [7:0]   ch;
		logic         typed;
		line_result_t want;
	} plan_row_t;

	localparam int PLAN_ROWS = 25;
	localparam plan_row_t DIRECTED_PLAN [0:PLAN_ROWS-1] = '{
		'{REQ_TX_EMPTY, 8'h00, 1'b1, {24'h000000, 2'b00}},  // disarmed, ignored
		'{REQ_TX_DONE,  8'hFF, 1'b1, {24'h000000, 2'b00}},
		'{REQ_ARM,      8'h00, 1'b1, {24'h010000, 2'b00}},
		'{REQ_TX_EMPTY, 8'hA5, 1'b1, {24'h000000, 2'b00}},  // nothing received yet
		'{REQ_RX,       8'h00, 1'b1, {24'h000000, 2'b00}},
		'{REQ_RX,       8'hFF, 1'b1, {24'h000000, 2'b00}},
		'{REQ_RX,       8'h5A, 1'b0, '0},
		'{REQ_RX,       CHAR_CR, 1'b1, {24'h010300, 2'b10}},  // close, auto arm
		'{REQ_TX_EMPTY, 8'h00, 1'b0, '0},
		'{REQ_TX_EMPTY, 8'h33, 1'b0, '0},
		'{REQ_TX_EMPTY, 8'hCC, 1'b0, '0},
		'{REQ_TX_EMPTY, 8'h00, 1'b1, {24'h000000, 2'b00}},  // exhausted
		'{REQ_TX_DONE,  8'h00, 1'b1, {24'h000000, 2'b00}},
		'{REQ_RX,       CHAR_LF, 1'b1, {24'h004000, 2'b10}},  // empty line
		'{REQ_ARM,      8'hFF, 1'b1, {24'h010000, 2'b00}},
		'{REQ_RX,       8'h80, 1'b0, '0},
		'{REQ_TX_EMPTY, 8'h00, 1'b0, '0},
		'{REQ_RX,       8'h7F, 1'b0, '0},
		'{REQ_RX,       CHAR_LF, 1'b0, '0},
		'{REQ_RX,       8'h01, 1'b0, '0},
		'{REQ_TX_EMPTY, 8'h00, 1'b0, '0},
		'{REQ_RX,       CHAR_CR, 1'b0, '0},  // close while sending
		'{REQ_TX_EMPTY, 8'h00, 1'b0, '0},
		'{REQ_TX_EMPTY, 8'h00, 1'b0, '0},
		'{REQ_TX_DONE,  8'hFF, 1'b0, '0}
	};

	localparam int RANDOM_EVENTS = 1700;
	localparam int QUIET_AFTER   = 1450;
	localparam int HOLD_AT       = 600;
	localparam int HOLD_CYCLES   = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	logic        idle_on = 1'b1;
	logic        sink_hold_req = 1'b0;
	int          events_sent = 0;
	int          mismatch_count = 0;

	// results still owed by the block, oldest first
	line_result_t expected_words [$];

	// predictor state: line store, lengths, receive side, transmitter
	logic [7:0]  line_mem [0:2*LINE_CAPACITY-1];
	int unsigned line_len [0:1] = '{0, 0};
	logic        rx_sel = 1'b0;
	int unsigned tx_pos = 0;
	logic        armed = 1'b0;
	logic        tx_finished = 1'b0;

	ping_pong_line_buffer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// next state and result word of one serial event
	function automatic line_result_t predict_line_event(input req_t kind, input logic [7:0] ch);
		line_result_t res;
		logic         tx_sel;
		int unsigned  base;
		res = '0;
		tx_sel = ~rx_sel;
		case (kind)
			REQ_RX: begin
				if (ch == CHAR_CR || ch == CHAR_LF) begin
					res.line_done  = 1'b1;
					res.closed_len = 6'(line_len[rx_sel]);
					res.closed_buf = rx_sel;
					rx_sel = ~rx_sel;
					line_len[rx_sel] = 0;
					tx_pos = 0;
					if (tx_finished)
						armed = 1'b1;
				end else if (line_len[rx_sel] < LINE_CAPACITY - 1) begin
					base = rx_sel ? LINE_CAPACITY : 0;
					line_mem[base + line_len[rx_sel]] = ch;
					line_len[rx_sel]++;
				end else begin
					res.dropped = 1'b1;
				end
			end
			REQ_TX_EMPTY: begin
				if (armed) begin
					if (tx_pos < line_len[tx_sel]) begin
						base = tx_sel ? LINE_CAPACITY : 0;
						res.tx_valid = 1'b1;
						res.tx_char  = line_mem[base + tx_pos];
						tx_pos++;
					end else begin
						armed = 1'b0;
						tx_finished = 1'b1;
						line_len[tx_sel] = 0;
						tx_pos = 0;
					end
				end
			end
			REQ_TX_DONE: begin
				tx_finished = 1'b0;
			end
			default: begin
				armed = 1'b1;
			end
		endcase
		res.armed_now = armed;
		return res;
	endfunction

	// offer one event, wait for the word to be taken, log its result
	task automatic send_event(input req_t kind, input logic [7:0] ch,
			input logic typed = 1'b0, input line_result_t typed_word = '0);
		line_result_t res;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = predict_line_event(kind, ch);
		expected_words.push_back(typed ? typed_word : res);
		events_sent++;
	endtask

	// stop offering until every owed result has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// stimulus: directed table, then random lines and noise
	initial begin : stimulus
		int         k;
		int         len;
		int         pick;
		logic [7:0] ch;
		bit         hold_done;
		hold_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < PLAN_ROWS; k++)
			send_event(DIRECTED_PLAN[k].kind, DIRECTED_PLAN[k].ch,
				DIRECTED_PLAN[k].typed, DIRECTED_PLAN[k].want);
		wait_for_results();

		while (events_sent < PLAN_ROWS + RANDOM_EVENTS) begin
			if (!hold_done && events_sent > HOLD_AT) begin
				sink_hold_req <= 1'b1;
				hold_done = 1'b1;
				// keep offering while the sink holds off
				repeat (4)
					send_event(REQ_TX_DONE, 8'($urandom));
			end
			if (events_sent > QUIET_AFTER)
				idle_on <= 1'b0;
			pick = $urandom_range(0, 39);
			if (pick == 0) begin
				wait_for_results();
			end else if (pick <= 5) begin
				// noise: any kind, any byte
				repeat ($urandom_range(1, 6))
					send_event(req_t'($urandom_range(0, 3)), 8'($urandom));
			end else if (pick <= 8) begin
				send_event(REQ_TX_DONE, 8'($urandom));
				send_event(REQ_ARM, 8'($urandom));
			end else begin
				// one line, transmit of the previous one interleaved
				if ($urandom_range(0, 3) == 0)
					send_event(REQ_ARM, 8'($urandom));
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 70)
					: $urandom_range(0, 12);
				for (k = 0; k < len; k++) begin
					do
						ch = 8'($urandom_range(0, 255));
					while (ch == CHAR_CR || ch == CHAR_LF);
					send_event(REQ_RX, ch);
					if ($urandom_range(0, 2) == 0)
						send_event(REQ_TX_EMPTY, 8'($urandom));
				end
				send_event(REQ_RX, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
				if ($urandom_range(0, 1) == 0)
					send_event(REQ_TX_DONE, 8'($urandom));
				repeat ($urandom_range(0, len + 2))
					send_event(REQ_TX_EMPTY, 8'($urandom));
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side ready: random stalls and one long hold-off
	initial begin : result_sink
		int n;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req <= 1'b0;
				m_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin : result_check
		line_result_t got;
		line_result_t want;
		logic         bad;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser};
			if (expected_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result word %h", $realtime, got);
			end else begin
				want = expected_words.pop_front();
				bad = (got.tx_valid   !== want.tx_valid)   ||
				      (got.tx_char    !== want.tx_char)    ||
				      (got.line_done  !== want.line_done)  ||
				      (got.closed_len !== want.closed_len) ||
				      (got.closed_buf !== want.closed_buf) ||
				      (got.dropped    !== want.dropped)    ||
				      (got.armed_now  !== want.armed_now)  ||
				      (got.pad        !== want.pad);
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch exp tdata %h tuser %b, got tdata %h tuser %b",
							$realtime, want[25:2], want[1:0], got[25:2], got[1:0]);
				end
			end
		end
	end

	// watchdog
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
hdl/pplb_pkg.sv
hdl/pplb_ram.sv
hdl/ping_pong_line_buffer_core.sv
hdl/pplb_checker.sv
tb/sv/tb_ping_pong_line_buffer_core.sv
